### rtl/srwu_pkg.sv
// Package with the item types, register numbers and field masks of the special register write unit.
package srwu_pkg;

   // Special register numbers.
   localparam logic [4:0] SEL_APSR      = 5'd0;
   localparam logic [4:0] SEL_IAPSR     = 5'd1;
   localparam logic [4:0] SEL_EAPSR     = 5'd2;
   localparam logic [4:0] SEL_XPSR      = 5'd3;
   localparam logic [4:0] SEL_IPSR      = 5'd5;
   localparam logic [4:0] SEL_EPSR      = 5'd6;
   localparam logic [4:0] SEL_IEPSR     = 5'd7;
   localparam logic [4:0] SEL_MSP       = 5'd8;
   localparam logic [4:0] SEL_PSP       = 5'd9;
   localparam logic [4:0] SEL_PRIMASK   = 5'd16;
   localparam logic [4:0] SEL_BASEPRI   = 5'd17;
   localparam logic [4:0] SEL_PRI_RAISE = 5'd18;
   localparam logic [4:0] SEL_FAULTMASK = 5'd19;
   localparam logic [4:0] SEL_CONTROL   = 5'd20;

   // Writable bits of the status word for each view.
   localparam logic [31:0] APSR_MASK = 32'hf800_0000;
   localparam logic [31:0] XPSR_MASK = 32'hfe00_fc00;
   localparam logic [31:0] EPSR_MASK = 32'h0600_fc00;

   typedef struct packed {
      logic [4:0]  reg_select;
      logic [31:0] write_value;
   } req_item_type;

   typedef struct packed {
      logic        unimplemented;
      logic [31:0] status_word;
      logic [31:0] main_stack_ptr;
      logic [31:0] process_stack_ptr;
      logic        irq_masked;
      logic        fault_masked;
      logic [7:0]  base_priority;
      logic [1:0]  control_bits;
   } rsp_item_type;

   // Architectural special register state. The stack pointers are kept by
   // name; control bit 1 tells which one is live.
   typedef struct packed {
      logic [31:0] psr;
      logic [31:0] msp;
      logic [31:0] psp;
      logic        primask;
      logic        faultmask;
      logic [7:0]  basepri;
      logic [1:0]  control;
   } arch_state_type;

endpackage

### rtl/srwu_exec.sv
// Next-state logic for one special register write.
module srwu_exec
   import srwu_pkg::*;
(
   input  req_item_type   item,
   input  arch_state_type cur_state,
   output arch_state_type next_state,
   output logic           unimplemented
);

   logic [7:0] new_pri;

   assign new_pri = item.write_value[7:0];

   always_comb begin
      next_state    = cur_state;
      unimplemented = 1'b0;
      case (item.reg_select)
         SEL_APSR, SEL_IAPSR: begin
            next_state.psr = (cur_state.psr & ~APSR_MASK) | (item.write_value & APSR_MASK);
         end
         SEL_EAPSR, SEL_XPSR: begin
            next_state.psr = (cur_state.psr & ~XPSR_MASK) | (item.write_value & XPSR_MASK);
         end
         SEL_IPSR: begin
            next_state = cur_state;
         end
         SEL_EPSR, SEL_IEPSR: begin
            next_state.psr = (cur_state.psr & ~EPSR_MASK) | (item.write_value & EPSR_MASK);
         end
         SEL_MSP: begin
            next_state.msp = item.write_value;
         end
         SEL_PSP: begin
            next_state.psp = item.write_value;
         end
         SEL_PRIMASK: begin
            next_state.primask = item.write_value[0];
         end
         SEL_BASEPRI: begin
            next_state.basepri = new_pri;
         end
         SEL_PRI_RAISE: begin
            // Only raises the masking level: a nonzero priority wins over a larger or zero one.
            if ((new_pri != 8'd0) &&
                ((new_pri < cur_state.basepri) || (cur_state.basepri == 8'd0))) begin
               next_state.basepri = new_pri;
            end
         end
         SEL_FAULTMASK: begin
            next_state.faultmask = item.write_value[0];
         end
         SEL_CONTROL: begin
            next_state.control = item.write_value[1:0];
         end
         default: begin
            unimplemented = 1'b1;
         end
      endcase
   end

endmodule

### rtl/special_register_write_unit_top.sv
// Top level of the special register write unit: input register, state, result register.
// Each item names a special register and carries a 32-bit value to write to it. The
// block applies the write to its copy of the core's special registers (status word,
// main and process stack pointers, PRIMASK, FAULTMASK, BASEPRI and CONTROL) and returns
// one result item per request that reports all of these registers after the write,
// plus an unimplemented flag for register numbers it does not handle; such a write
// leaves every register unchanged. An accepted item waits in the input register; the
// write logic then updates the state and loads the result register together, and the
// result waits there until it leaves. A new item can be accepted in every cycle while
// the result side does not stall; the throughput of one item per cycle is set by the
// single state update path, which reads the state left by the previous item and
// writes it back. A stall on the result side holds the result register and, once the
// input register is full too, raises req_stall. All state resets to zero, main stack
// selected.
module special_register_write_unit_top
   import srwu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data
);

   // Input register.
   logic         in_valid_ff;
   logic         in_valid_in;
   req_item_type in_item_ff;

   // Result register.
   logic         out_valid_ff;
   logic         out_valid_in;
   rsp_item_type out_item_ff;
   rsp_item_type out_item_in;

   // Special register state.
   arch_state_type state_ff;
   arch_state_type state_next;
   logic           exec_unimpl;

   logic out_free;
   logic advance;
   logic req_take;

   // The result register can take a new item when empty or when its item leaves now.
   assign out_free = !out_valid_ff || !rsp_stall;
   // The item in the input register is executed and committed.
   assign advance  = in_valid_ff && out_free;
   // The input register is free when empty or when its item moves on now.
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   srwu_exec u_exec (
      .item          (in_item_ff),
      .cur_state     (state_ff),
      .next_state    (state_next),
      .unimplemented (exec_unimpl)
   );

   always_comb begin
      out_item_in.unimplemented     = exec_unimpl;
      out_item_in.status_word       = state_next.psr;
      out_item_in.main_stack_ptr    = state_next.msp;
      out_item_in.process_stack_ptr = state_next.psp;
      out_item_in.irq_masked        = state_next.primask;
      out_item_in.fault_masked      = state_next.faultmask;
      out_item_in.base_priority     = state_next.basepri;
      out_item_in.control_bits      = state_next.control;
   end

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_next;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_data;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   // A waiting result always reports the state as it stands, since state and result
   // are loaded together.
   a_result_matches_state: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_item_ff.status_word == state_ff.psr) &&
                       (out_item_ff.main_stack_ptr == state_ff.msp) &&
                       (out_item_ff.process_stack_ptr == state_ff.psp) &&
                       (out_item_ff.base_priority == state_ff.basepri) &&
                       (out_item_ff.control_bits == state_ff.control))
      else $error("result register disagrees with special register state");

   // An unknown register number leaves every register untouched.
   a_unimpl_no_change: assert property (@(posedge clock) disable iff (reset)
      (advance && exec_unimpl) |=> (state_ff == $past(state_ff)))
      else $error("unimplemented write changed state");

   // A priority raise write never lowers a nonzero masking level to a weaker one.
   a_pri_raise_monotone: assert property (@(posedge clock) disable iff (reset)
      (advance && (in_item_ff.reg_select == SEL_PRI_RAISE) && (state_ff.basepri != 8'd0))
      |=> (state_ff.basepri <= $past(state_ff.basepri)) && (state_ff.basepri != 8'd0))
      else $error("priority raise weakened the priority mask");

   // State moves only when an item is committed.
   a_state_only_on_advance: assert property (@(posedge clock) disable iff (reset)
      !advance |=> (state_ff == $past(state_ff)))
      else $error("special register state changed without a write");

endmodule

### bench/tb_special_register_write_unit_top.sv
// Self-checking testbench for the special register write unit with its own state predictor.
`timescale 1ns / 1ps

module tb_special_register_write_unit_top;
   import srwu_pkg::*;

   // Register numbers the block does not implement. They are used to hit the error path.
   localparam logic [4:0] SEL_RESERVED = 5'd4;
   localparam logic [4:0] SEL_MID_GAP  = 5'd10;
   localparam logic [4:0] SEL_LAST     = 5'd31;

   localparam int RANDOM_ITEMS  = 1500;
   localparam int DRAIN_EVERY   = 250;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int PRINT_LIMIT   = 40;
   localparam int SETTLE_CYCLES = 8;

   // Shadow copy of the special registers. The two stack pointers are held as the
   // live one and the banked one, so a CONTROL write that changes stacks swaps them.
   typedef struct packed {
      logic [31:0] psr;
      logic [31:0] live_sp;
      logic [31:0] banked_sp;
      logic        on_process;
      logic        primask;
      logic        faultmask;
      logic [7:0]  basepri;
      logic [1:0]  control;
   } shadow_regs_type;

   // An item waiting to be sent. When drain_first is set, the sender holds it back
   // until every result of the items before it has come out.
   typedef struct packed {
      logic         drain_first;
      req_item_type item;
   } pending_item_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_data;

   shadow_regs_type  shadow = '0;
   pending_item_type pending_writes[$];
   rsp_item_type     expected_states[$];

   // Counters that cross between the sender and the checker are updated with
   // nonblocking assignments, so both sides see stable values at each edge.
   int unsigned items_in    = 0;
   int unsigned results_out = 0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;

   // Sender pacing.
   int burst_left = 0;
   int gap_left   = 0;

   // Receiver stall pattern.
   int stall_mode = 0;
   int stall_mode_left = 0;

   special_register_write_unit_top DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Prints one line per mismatch up to a limit and counts all of them.
   task automatic report_error(input string what);
      if (error_count < PRINT_LIMIT) begin
         $display("ERROR at %0t ns, result %0d: %s", $time, results_out, what);
      end
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_error($sformatf("%s is %h, expected %h", name, got, want));
      end
   endtask

   // Applies one accepted write to the shadow registers and returns the result item
   // the block must produce for it.
   function automatic rsp_item_type predict_write(input req_item_type item);
      rsp_item_type res;
      logic [31:0]  value;
      logic [31:0]  swap_tmp;
      logic [7:0]   low_byte;
      value = item.write_value;
      low_byte = value[7:0];
      res = '0;
      case (item.reg_select)
         SEL_APSR, SEL_IAPSR: begin
            shadow.psr = (shadow.psr & ~APSR_MASK) | (value & APSR_MASK);
         end
         SEL_EAPSR, SEL_XPSR: begin
            shadow.psr = (shadow.psr & ~XPSR_MASK) | (value & XPSR_MASK);
         end
         SEL_IPSR: begin
            // Writes to the exception number are ignored, but they are not an error.
         end
         SEL_EPSR, SEL_IEPSR: begin
            shadow.psr = (shadow.psr & ~EPSR_MASK) | (value & EPSR_MASK);
         end
         SEL_MSP: begin
            if (shadow.on_process) shadow.banked_sp = value;
            else shadow.live_sp = value;
         end
         SEL_PSP: begin
            if (shadow.on_process) shadow.live_sp = value;
            else shadow.banked_sp = value;
         end
         SEL_PRIMASK: begin
            shadow.primask = value[0];
         end
         SEL_BASEPRI: begin
            shadow.basepri = low_byte;
         end
         SEL_PRI_RAISE: begin
            // Only raises the priority mask: a zero value never takes effect, and a
            // nonzero value wins over a larger or disabled (zero) current value.
            if (low_byte != 8'd0 && (low_byte < shadow.basepri || shadow.basepri == 8'd0)) begin
               shadow.basepri = low_byte;
            end
         end
         SEL_FAULTMASK: begin
            shadow.faultmask = value[0];
         end
         SEL_CONTROL: begin
            shadow.control = value[1:0];
            if (value[1] != shadow.on_process) begin
               swap_tmp = shadow.live_sp;
               shadow.live_sp = shadow.banked_sp;
               shadow.banked_sp = swap_tmp;
               shadow.on_process = value[1];
            end
         end
         default: begin
            res.unimplemented = 1'b1;
         end
      endcase
      res.status_word       = shadow.psr;
      res.main_stack_ptr    = shadow.on_process ? shadow.banked_sp : shadow.live_sp;
      res.process_stack_ptr = shadow.on_process ? shadow.live_sp : shadow.banked_sp;
      res.irq_masked        = shadow.primask;
      res.fault_masked      = shadow.faultmask;
      res.base_priority     = shadow.basepri;
      res.control_bits      = shadow.control;
      return res;
   endfunction

   task automatic queue_write(input logic [4:0] sel, input logic [31:0] value,
                              input logic drain);
      pending_item_type p;
      p.drain_first = drain;
      p.item.reg_select = sel;
      p.item.write_value = value;
      pending_writes.push_back(p);
   endtask

   // Picks a random register and value. Most items go to implemented registers; values
   // lean toward all zeros, all ones and small bytes so that the priority compare and
   // the masked status word updates see their edges.
   task automatic queue_random_write(input logic drain);
      logic [4:0]  sel;
      logic [31:0] value;
      if ($urandom_range(0, 99) < 12) begin
         case ($urandom_range(0, 2))
            0:       sel = SEL_RESERVED;
            1:       sel = 5'($urandom_range(SEL_PSP + 1, SEL_PRIMASK - 1));
            default: sel = 5'($urandom_range(SEL_CONTROL + 1, SEL_LAST));
         endcase
      end else begin
         case ($urandom_range(0, 13))
            0:       sel = SEL_APSR;
            1:       sel = SEL_IAPSR;
            2:       sel = SEL_EAPSR;
            3:       sel = SEL_XPSR;
            4:       sel = SEL_IPSR;
            5:       sel = SEL_EPSR;
            6:       sel = SEL_IEPSR;
            7:       sel = SEL_MSP;
            8:       sel = SEL_PSP;
            9:       sel = SEL_PRIMASK;
            10:      sel = SEL_BASEPRI;
            11:      sel = SEL_PRI_RAISE;
            12:      sel = SEL_FAULTMASK;
            default: sel = SEL_CONTROL;
         endcase
      end
      case ($urandom_range(0, 9))
         0:       value = '0;
         1:       value = '1;
         2:       value = $urandom_range(0, 255);
         3:       value = 32'({$urandom, 8'h00} | $urandom_range(0, 15));
         default: value = $urandom;
      endcase
      queue_write(sel, value, drain);
   endtask

   // Stimulus: a directed opening that walks every register and the corner cases of
   // the priority compare and the stack swap, then a long random run. The sender is
   // made to drain the pipeline now and then so that it empties completely.
   initial begin
      queue_write(SEL_IPSR, '1, 1'b0);
      queue_write(SEL_APSR, '1, 1'b0);
      queue_write(SEL_IAPSR, '0, 1'b0);
      queue_write(SEL_EAPSR, '1, 1'b0);
      queue_write(SEL_XPSR, '0, 1'b0);
      queue_write(SEL_EPSR, '1, 1'b0);
      queue_write(SEL_IEPSR, '0, 1'b0);
      queue_write(SEL_MSP, '1, 1'b0);
      queue_write(SEL_PSP, 32'h1234_5678, 1'b0);
      // Move to the process stack, write both pointers while it is the live one,
      // rewrite CONTROL without a stack change, then move back.
      queue_write(SEL_CONTROL, 32'h0000_0002, 1'b0);
      queue_write(SEL_MSP, '0, 1'b0);
      queue_write(SEL_PSP, '1, 1'b0);
      queue_write(SEL_CONTROL, 32'h0000_0003, 1'b0);
      queue_write(SEL_CONTROL, 32'hffff_fffc, 1'b0);
      queue_write(SEL_PRIMASK, '1, 1'b0);
      queue_write(SEL_PRIMASK, 32'hffff_fffe, 1'b0);
      queue_write(SEL_FAULTMASK, '1, 1'b0);
      queue_write(SEL_FAULTMASK, '0, 1'b0);
      // The priority mask starts out disabled, so the first raise always takes.
      queue_write(SEL_PRI_RAISE, 32'h0000_0080, 1'b1);
      queue_write(SEL_PRI_RAISE, 32'h0000_00ff, 1'b0);
      queue_write(SEL_PRI_RAISE, 32'hffff_ff00, 1'b0);
      queue_write(SEL_PRI_RAISE, 32'h0000_0040, 1'b0);
      queue_write(SEL_BASEPRI, 32'h0000_0100, 1'b0);
      queue_write(SEL_RESERVED, '1, 1'b0);
      queue_write(SEL_LAST, '1, 1'b0);
      queue_write(SEL_MID_GAP, '0, 1'b0);
      for (int i = 1; i <= RANDOM_ITEMS; i++) begin
         queue_random_write(i % DRAIN_EVERY == 0);
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Wait until every item is sent and every expected result has come out, then
      // keep the clock running so a stray extra result would be seen. The
      // falling edge is used so that the values updated at the rising edge have settled.
      do @(negedge clock);
      while (pending_writes.size() != 0 || req_valid || items_in != results_out);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (items_in != results_out) begin
         report_error($sformatf("%0d expected results never arrived", items_in - results_out));
      end
      if (error_count == 0) begin
         $display("tb_special_register_write_unit_top: clean");
      end else begin
         $display("tb_special_register_write_unit_top: errors");
      end
      $finish;
   end

   // Sender. Items go out in bursts of random length separated by random gaps, with
   // now and then a long burst with no gaps at all. An offered item is held until it
   // is accepted, and the prediction is made at the edge where it is accepted, which
   // is the order in which the block applies the writes.
   always @(posedge clock) begin
      logic accepted;
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         accepted = req_valid && !req_stall;
         if (accepted) begin
            expected_states.push_back(predict_write(req_data));
            items_in <= items_in + 1;
         end
         next_valid = req_valid && !accepted;
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_writes.size() != 0 &&
                         !(pending_writes[0].drain_first &&
                           (accepted || items_in != results_out))) begin
               req_data <= pending_writes[0].item;
               pending_writes.pop_front();
               next_valid = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else if ($urandom_range(0, 9) < 2) begin
                  burst_left = $urandom_range(100, 300);
                  gap_left = 0;
               end else begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = $urandom_range(0, 8);
               end
            end
         end
         req_valid <= next_valid;
      end
   end

   // Receiver stall pattern. It switches between no stalls, light random stalls, a
   // fixed periodic pattern and heavy random stalls, each for a random stretch.
   always @(posedge clock) begin
      logic stall_next;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_mode_left = $urandom_range(16, 400);
         end else begin
            stall_mode_left--;
         end
         case (stall_mode)
            0:       stall_next = 1'b0;
            1:       stall_next = $urandom_range(0, 99) < 25;
            2:       stall_next = (cycle_count % 5) < 2;
            default: stall_next = $urandom_range(0, 99) < 75;
         endcase
         rsp_stall <= stall_next;
      end
   end

   // Checker. Each accepted result is compared field by field with the oldest
   // expectation. The count of items accepted before this edge tells whether an
   // expectation exists, so an item accepted at the same edge never pairs up here.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (results_out >= items_in) begin
            report_error("result item with no write waiting for it");
         end else begin
            want = expected_states.pop_front();
            results_out <= results_out + 1;
            check_field("unimplemented", 32'(rsp_data.unimplemented),
                        32'(want.unimplemented));
            check_field("status_word", rsp_data.status_word, want.status_word);
            check_field("main_stack_ptr", rsp_data.main_stack_ptr, want.main_stack_ptr);
            check_field("process_stack_ptr", rsp_data.process_stack_ptr,
                        want.process_stack_ptr);
            check_field("irq_masked", 32'(rsp_data.irq_masked), 32'(want.irq_masked));
            check_field("fault_masked", 32'(rsp_data.fault_masked),
                        32'(want.fault_masked));
            check_field("base_priority", 32'(rsp_data.base_priority),
                        32'(want.base_priority));
            check_field("control_bits", 32'(rsp_data.control_bits),
                        32'(want.control_bits));
         end
      end
   end

   // Watchdog. The limit is many times the slowest correct run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_special_register_write_unit_top: errors");
         $finish;
      end
   end

endmodule
